### sv/min_spacing_point_admission_defines.svh
// ----------------------------------------------------------------------------
// Minimum-spacing point admission: assertion macros
// Shared concurrent check forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_SPACING_POINT_ADMISSION_DEFINES_SVH
`define MIN_SPACING_POINT_ADMISSION_DEFINES_SVH

// Same-cycle implication
`define MSPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MSPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mspa_pkg.sv
// ----------------------------------------------------------------------------
// mspa_pkg
// Types and constants of the minimum-spacing point admission block.
// ----------------------------------------------------------------------------
package mspa_pkg;

  // Point store geometry
  localparam int CAPACITY = 8192;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 14;

  // Register indexes
  localparam logic [1:0] REG_MIN_DISTANCE   = 2'd0;
  localparam logic [1:0] REG_MAX_COUNT      = 2'd1;
  localparam logic [1:0] REG_MAX_ATTEMPTS   = 2'd2;
  localparam logic [1:0] REG_ALLOW_OVERLAPS = 2'd3;

  // Register reset values
  localparam logic [14:0] MIN_DISTANCE_RST = 15'd1802;
  localparam logic [13:0] MAX_COUNT_RST    = 14'd6000;
  localparam logic [15:0] MAX_ATTEMPTS_RST = 16'd6000;

  // Input beat
  typedef struct packed {
    logic signed [15:0] cand_z;
    logic signed [15:0] cand_x;
  } in_t;

  // Result beat
  typedef struct packed {
    logic              accepted;
    logic [12:0]       slot_index;
    logic [CNT_W-1:0]  stored_count;
    logic              finished;
  } out_t;

  // Distance pipeline status toward the controller
  typedef struct packed {
    logic busy;
    logic hit;
  } dist_stat_t;

endpackage

### sv/mspa_ram.sv
// ----------------------------------------------------------------------------
// mspa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mspa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/mspa_dist.sv
// ----------------------------------------------------------------------------
// mspa_dist
// Three-stage squared-distance pipeline: difference, square, sum and compare.
// ----------------------------------------------------------------------------
module mspa_dist (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    issue,
  input  mspa_pkg::in_t           cand,
  input  logic [31:0]             point,
  input  logic [29:0]             limit,
  output mspa_pkg::dist_stat_t    stat
);
  import mspa_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic signed [16:0] dx_r, dz_r;
  logic [33:0]        sqx_r, sqz_r;
  logic signed [33:0] sqx_full, sqz_full;
  logic [34:0]        d2;

  // Beat tracking: read data arrives in the cycle after issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign sqx_full = dx_r * dx_r;
  assign sqz_full = dz_r * dz_r;

  // Datapath registers
  always_ff @(posedge clk) begin
    dx_r  <= 17'(cand.cand_x) - 17'(signed'(point[15:0]));
    dz_r  <= 17'(cand.cand_z) - 17'(signed'(point[31:16]));
    sqx_r <= 34'(unsigned'(sqx_full));
    sqz_r <= 34'(unsigned'(sqz_full));
  end

  // Strictly closer than the minimum spacing blocks the candidate
  assign d2        = 35'(sqx_r) + 35'(sqz_r);
  assign stat.hit  = v3_r && (d2 < 35'(limit));
  assign stat.busy = v1_r || v2_r || v3_r;

endmodule

### sv/min_spacing_point_admission.sv
// ----------------------------------------------------------------------------
// min_spacing_point_admission
// Admits a candidate point when no stored point lies closer than min_distance.
// ----------------------------------------------------------------------------
// Only one item is in flight. A candidate is rejected once a limit is reached;
//   with overlaps allowed or an empty store it skips the spacing check, otherwise
//   the stored points are scanned at one stored point per cycle from the store's
//   read port.
// Reset: synchronous, active low; counts clear, registers take their defaults,
//   point store contents are not cleared (only entries below the count are read).
module min_spacing_point_admission (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mspa_pkg::in_t          in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mspa_pkg::out_t         out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  import mspa_pkg::*;

`include "min_spacing_point_admission_defines.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t           state_r, state_nxt;
  in_t              cand_r, cand_nxt;
  logic [29:0]      limit_r, limit_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      attempt_r, attempt_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             live_r, live_nxt;
  logic             hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic [14:0]      min_dist_r;
  logic [13:0]      max_count_r;
  logic [15:0]      max_att_r;
  logic             overlaps_r;

  logic [CNT_W-1:0] count_limit;
  logic             limits_hit;
  logic             in_fire;
  logic             out_free;
  logic             issue;
  logic             mem_we;
  logic             acc;
  logic [CNT_W-1:0] count_inc;
  logic [31:0]      rd_point;
  dist_stat_t       dstat;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r  <= MIN_DISTANCE_RST;
      max_count_r <= MAX_COUNT_RST;
      max_att_r   <= MAX_ATTEMPTS_RST;
      overlaps_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_DISTANCE:   min_dist_r  <= cfg_data[14:0];
        REG_MAX_COUNT:      max_count_r <= cfg_data[13:0];
        REG_MAX_ATTEMPTS:   max_att_r   <= cfg_data;
        REG_ALLOW_OVERLAPS: overlaps_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Limit checks; the store depth caps max_count
  assign count_limit = (CNT_W'(max_count_r) > CAP_CNT) ? CAP_CNT : CNT_W'(max_count_r);
  assign limits_hit  = (count_r >= count_limit) || (attempt_r >= max_att_r);

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign acc      = live_r && !hit_r;
  assign count_inc = count_r + CNT_W'(acc);

  // Controller next state
  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    limit_nxt     = limit_r;
    count_nxt     = count_r;
    attempt_nxt   = attempt_r;
    issue_nxt     = issue_r;
    live_nxt      = live_r;
    hit_nxt       = hit_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    issue         = 1'b0;
    mem_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cand_nxt  = in_data;
          limit_nxt = 30'(min_dist_r) * 30'(min_dist_r);
          live_nxt  = !limits_hit;
          hit_nxt   = 1'b0;
          issue_nxt = '0;
          if (!limits_hit) begin
            attempt_nxt = attempt_r + 16'd1;
          end
          if (!limits_hit && !overlaps_r && (count_r != '0)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        issue   = (issue_r < count_r);
        hit_nxt = hit_r || dstat.hit;
        if (issue) begin
          issue_nxt = issue_r + CNT_W'(1);
        end else if (!dstat.busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          mem_we                    = acc;
          count_nxt                 = count_inc;
          out_valid_nxt             = 1'b1;
          out_data_nxt.accepted     = acc;
          out_data_nxt.slot_index   = acc ? count_r[ADDR_W-1:0] : '0;
          out_data_nxt.stored_count = count_inc;
          out_data_nxt.finished     = (count_inc >= count_limit) ||
                                      (attempt_r >= max_att_r);
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      attempt_r   <= '0;
      issue_r     <= '0;
      live_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      attempt_r   <= attempt_nxt;
      issue_r     <= issue_nxt;
      live_r      <= live_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    limit_r    <= limit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Point store: x in the low half, z in the high half
  mspa_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata ({cand_r.cand_z, cand_r.cand_x}),
    .raddr (issue_r[ADDR_W-1:0]),
    .rdata (rd_point)
  );

  // Distance check pipeline
  mspa_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .cand  (cand_r),
    .point (rd_point),
    .limit (limit_r),
    .stat  (dstat)
  );

  // Checks
  `MSPA_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CAP_CNT, "point count above store depth")
  `MSPA_ASSERT_NOW(a_slot_match, out_valid_r && out_data_r.accepted,
    CNT_W'(out_data_r.slot_index) == (out_data_r.stored_count - CNT_W'(1)),
    "slot index does not match stored count")
  `MSPA_ASSERT_NEXT(a_count_step, 1'b1,
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)),
    "point count moved by more than one")
  `MSPA_ASSERT_NOW(a_scan_quiet, state_r == S_IDLE, !dstat.busy,
    "distance pipeline busy while idle")

endmodule
